// File: rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants of the radio session stack: operation codes,
// session entry layout, controller commands and datapath status.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int DEPTH_DEF = 4;

  localparam int ID_W   = 8;
  localparam int WAIT_W = 16;
  localparam int OP_W   = 3;

  localparam logic [WAIT_W-1:0] WAIT_MAX   = 16'hFFFF;
  localparam logic [ID_W-1:0]   MASK_RESET = 8'd64;

  typedef enum logic [OP_W-1:0] {
    OP_NEW      = 3'd0,
    OP_EXTEND   = 3'd1,
    OP_POP      = 3'd2,
    OP_FLUSH    = 3'd3,
    OP_GETNEXT  = 3'd4,
    OP_INVITE   = 3'd5,
    OP_POSTPONE = 3'd6,
    OP_QUERY    = 3'd7
  } op_e;

  typedef struct packed {
    logic [ID_W-1:0]   applet;
    logic [WAIT_W-1:0] wait_cnt;
    logic [ID_W-1:0]   channel;
    logic [ID_W-1:0]   net_state;
    logic [ID_W-1:0]   dialog;
  } sess_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_SCAN,
    ACT_INSERT,
    ACT_DROP,
    ACT_GETNEXT,
    ACT_INVITE,
    ACT_POSTPONE,
    ACT_RESP
  } act_e;

  typedef struct packed {
    act_e act;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic count_zero;
    logic room_new;
    logic room_ext;
    logic scan_hit;
    logic scan_end;
    logic front_init;
  } stat_t;

endpackage

// File: rtl/radio_session_stack_top.sv
// ----------------------------------------------------------------------------
// radio_session_stack_top
// Ordered session list of a radio MAC with new, extend, pop, flush, get-next,
// invite, postpone and query operations; one result word per input word.
// ----------------------------------------------------------------------------
// One word is worked at a time. Query, new, pop, get-next and invite go
// from acceptance through an execute step and a result step. Extend and
// postpone walk the list one entry per cycle to find the first init session
// before they execute; extend starts behind the front and postpone at the
// front. Flush drops one front session per cycle until the list is empty
// or an init session is at its front. The result sits in an output
// register; the input side stalls while a word is being worked, and a
// result held up by a stall on the output delays the return to accepting.
// The init mask may be written only while the block is idle.
module radio_session_stack_top #(
  parameter int DEPTH = rss_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rss_pkg::ID_W-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [rss_pkg::OP_W-1:0]   in_op_i,
  input  logic [rss_pkg::ID_W-1:0]   in_applet_id_i,
  input  logic [rss_pkg::WAIT_W-1:0] in_wait_or_delay_i,
  input  logic [rss_pkg::ID_W-1:0]   in_channel_i,
  input  logic [rss_pkg::ID_W-1:0]   in_net_state_i,
  input  logic [rss_pkg::ID_W-1:0]   in_random_id_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       out_accepted_o,
  output logic [3:0]                 out_slot_o,
  output logic [4:0]                 out_count_o,
  output logic signed [4:0]          out_free_slots_o,
  output logic [rss_pkg::WAIT_W-1:0] out_next_wait_o,
  output logic [rss_pkg::ID_W-1:0]   out_front_channel_o,
  output logic [rss_pkg::ID_W-1:0]   out_front_net_state_o,
  output logic [rss_pkg::ID_W-1:0]   out_front_applet_o,
  output logic [rss_pkg::ID_W-1:0]   out_front_dialog_o,
  output logic [rss_pkg::WAIT_W-1:0] out_follower_wait_o
);

  rss_pkg::cmd_t  cmd;
  rss_pkg::stat_t stat;

  rss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_op_i     (in_op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_op_i               (in_op_i),
    .in_applet_id_i        (in_applet_id_i),
    .in_wait_or_delay_i    (in_wait_or_delay_i),
    .in_channel_i          (in_channel_i),
    .in_net_state_i        (in_net_state_i),
    .in_random_id_i        (in_random_id_i),
    .out_accepted_o        (out_accepted_o),
    .out_slot_o            (out_slot_o),
    .out_count_o           (out_count_o),
    .out_free_slots_o      (out_free_slots_o),
    .out_next_wait_o       (out_next_wait_o),
    .out_front_channel_o   (out_front_channel_o),
    .out_front_net_state_o (out_front_net_state_o),
    .out_front_applet_o    (out_front_applet_o),
    .out_front_dialog_o    (out_front_dialog_o),
    .out_follower_wait_o   (out_follower_wait_o)
  );

endmodule

// File: rtl/rss_ctrl.sv
// ----------------------------------------------------------------------------
// rss_ctrl
// Sequencer of the session stack: accepts one word, steps the datapath
// through scan, update and flush cycles, then loads the result register.
// ----------------------------------------------------------------------------
module rss_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [rss_pkg::OP_W-1:0] in_op_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  rss_pkg::stat_t           stat_i,
  output rss_pkg::cmd_t            cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  rss_pkg::op_e in_op;

  assign in_op       = rss_pkg::op_e'(in_op_i);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o.act   = rss_pkg::ACT_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = rss_pkg::ACT_LOAD;
          priority if (in_op == rss_pkg::OP_EXTEND || in_op == rss_pkg::OP_POSTPONE) begin
            state_d = S_SCAN;
          end else if (in_op == rss_pkg::OP_FLUSH) begin
            state_d = S_FLUSH;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_SCAN: begin
        // walk one entry a cycle until an init session or the back
        if (stat_i.scan_hit || stat_i.scan_end) begin
          state_d = S_EXEC;
        end else begin
          cmd_o.act = rss_pkg::ACT_SCAN;
        end
      end
      S_FLUSH: begin
        if (!stat_i.count_zero && !stat_i.front_init) begin
          cmd_o.act = rss_pkg::ACT_DROP;
        end else begin
          state_d = S_RESP;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
        unique case (stat_i.op)
          rss_pkg::OP_NEW: begin
            if (stat_i.room_new) cmd_o.act = rss_pkg::ACT_INSERT;
          end
          rss_pkg::OP_EXTEND: begin
            if (stat_i.room_ext) cmd_o.act = rss_pkg::ACT_INSERT;
          end
          rss_pkg::OP_POP: begin
            if (!stat_i.count_zero) cmd_o.act = rss_pkg::ACT_DROP;
          end
          rss_pkg::OP_GETNEXT:  cmd_o.act = rss_pkg::ACT_GETNEXT;
          rss_pkg::OP_INVITE:   cmd_o.act = rss_pkg::ACT_INVITE;
          rss_pkg::OP_POSTPONE: cmd_o.act = rss_pkg::ACT_POSTPONE;
          default:              cmd_o.act = rss_pkg::ACT_NONE;
        endcase
      end
      S_RESP: begin
        // result register free or being emptied this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.act   = rss_pkg::ACT_RESP;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/rss_datapath.sv
// ----------------------------------------------------------------------------
// rss_datapath
// Session entries, count, init mask, scan pointer and result register of the
// session stack; each cycle it carries out the one command it is given.
// ----------------------------------------------------------------------------
module rss_datapath #(
  parameter int DEPTH = rss_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rss_pkg::cmd_t              cmd_i,
  output rss_pkg::stat_t             stat_o,
  input  logic                       cfg_we_i,
  input  logic [rss_pkg::ID_W-1:0]   cfg_wdata_i,
  input  logic [rss_pkg::OP_W-1:0]   in_op_i,
  input  logic [rss_pkg::ID_W-1:0]   in_applet_id_i,
  input  logic [rss_pkg::WAIT_W-1:0] in_wait_or_delay_i,
  input  logic [rss_pkg::ID_W-1:0]   in_channel_i,
  input  logic [rss_pkg::ID_W-1:0]   in_net_state_i,
  input  logic [rss_pkg::ID_W-1:0]   in_random_id_i,
  output logic                       out_accepted_o,
  output logic [3:0]                 out_slot_o,
  output logic [4:0]                 out_count_o,
  output logic signed [4:0]          out_free_slots_o,
  output logic [rss_pkg::WAIT_W-1:0] out_next_wait_o,
  output logic [rss_pkg::ID_W-1:0]   out_front_channel_o,
  output logic [rss_pkg::ID_W-1:0]   out_front_net_state_o,
  output logic [rss_pkg::ID_W-1:0]   out_front_applet_o,
  output logic [rss_pkg::ID_W-1:0]   out_front_dialog_o,
  output logic [rss_pkg::WAIT_W-1:0] out_follower_wait_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  rss_pkg::sess_t ent_q [DEPTH];
  rss_pkg::sess_t ent_d [DEPTH];
  rss_pkg::sess_t item_q, item_d;
  rss_pkg::op_e   op_q, op_d;

  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              scan_q, scan_d;
  logic [rss_pkg::ID_W-1:0]   mask_q;
  logic                       acc_q, acc_d;
  logic [IW-1:0]              slot_q, slot_d;
  logic [rss_pkg::WAIT_W-1:0] nw_q, nw_d;
  logic                       got_q, got_d;

  logic [IW-1:0]              scan_idx;
  rss_pkg::sess_t             scan_ent;
  logic                       scan_hit;
  logic [CW-1:0]              ins_pos;
  logic [rss_pkg::WAIT_W:0]   sum;
  logic [rss_pkg::WAIT_W-1:0] sat_wait;
  logic                       have_front;
  logic                       have_follower;

  assign scan_idx      = scan_q[IW-1:0];
  assign scan_ent      = ent_q[scan_idx];
  assign scan_hit      = (scan_q < count_q) && ((scan_ent.net_state & mask_q) != '0);
  assign have_front    = (count_q != '0);
  assign have_follower = (count_q >= CW'(2));

  // extend goes before the init session found, else to the back
  assign ins_pos = (op_q == rss_pkg::OP_EXTEND && scan_hit) ? scan_q : count_q;

  assign sum      = {1'b0, scan_ent.wait_cnt} + {1'b0, item_q.wait_cnt};
  assign sat_wait = sum[rss_pkg::WAIT_W] ? rss_pkg::WAIT_MAX : sum[rss_pkg::WAIT_W-1:0];

  assign stat_o.op         = op_q;
  assign stat_o.count_zero = !have_front;
  assign stat_o.room_new   = (count_q <= CW'(DEPTH - 2));
  assign stat_o.room_ext   = (count_q < CW'(DEPTH));
  assign stat_o.scan_hit   = scan_hit;
  assign stat_o.scan_end   = (scan_q >= count_q);
  assign stat_o.front_init = have_front && ((ent_q[0].net_state & mask_q) != '0);

  always_comb begin
    ent_d   = ent_q;
    item_d  = item_q;
    op_d    = op_q;
    count_d = count_q;
    scan_d  = scan_q;
    acc_d   = acc_q;
    slot_d  = slot_q;
    nw_d    = nw_q;
    got_d   = got_q;
    unique case (cmd_i.act)
      rss_pkg::ACT_LOAD: begin
        op_d             = rss_pkg::op_e'(in_op_i);
        item_d.applet    = in_applet_id_i;
        item_d.wait_cnt  = in_wait_or_delay_i;
        item_d.channel   = in_channel_i;
        item_d.net_state = in_net_state_i;
        item_d.dialog    = in_random_id_i;
        acc_d            = 1'b0;
        slot_d           = '0;
        nw_d             = '0;
        got_d            = 1'b0;
        scan_d           = (rss_pkg::op_e'(in_op_i) == rss_pkg::OP_EXTEND) ? CW'(1) : '0;
      end
      rss_pkg::ACT_SCAN: begin
        scan_d = scan_q + CW'(1);
      end
      rss_pkg::ACT_INSERT: begin
        for (int k = 1; k < DEPTH; k++) begin
          if (CW'(k) > ins_pos) ent_d[k] = ent_q[k-1];
        end
        for (int k = 0; k < DEPTH; k++) begin
          if (CW'(k) == ins_pos) ent_d[k] = item_q;
        end
        count_d = count_q + CW'(1);
        acc_d   = 1'b1;
        slot_d  = ins_pos[IW-1:0];
      end
      rss_pkg::ACT_DROP: begin
        for (int k = 0; k < DEPTH - 1; k++) begin
          ent_d[k] = ent_q[k+1];
        end
        count_d = count_q - CW'(1);
      end
      rss_pkg::ACT_GETNEXT: begin
        if (have_front) begin
          nw_d              = ent_q[0].wait_cnt;
          ent_d[0].wait_cnt = '0;
        end
        got_d = 1'b1;
      end
      rss_pkg::ACT_INVITE: begin
        if (have_follower) begin
          ent_d[1].wait_cnt  = '0;
          ent_d[1].net_state = ent_q[1].net_state & ~mask_q;
        end
      end
      rss_pkg::ACT_POSTPONE: begin
        if (scan_hit) begin
          for (int k = 0; k < DEPTH; k++) begin
            if (IW'(k) == scan_idx) ent_d[k].wait_cnt = sat_wait;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      scan_q  <= '0;
      mask_q  <= rss_pkg::MASK_RESET;
    end else begin
      count_q <= count_d;
      scan_q  <= scan_d;
      if (cfg_we_i) mask_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    item_q <= item_d;
    op_q   <= op_d;
    acc_q  <= acc_d;
    slot_q <= slot_d;
    nw_q   <= nw_d;
    got_q  <= got_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == rss_pkg::ACT_RESP) begin
      out_accepted_o      <= acc_q;
      out_slot_o          <= 4'(slot_q);
      out_count_o         <= 5'(count_q);
      out_free_slots_o    <= 5'(DEPTH) - 5'(count_q) - 5'd1;
      out_next_wait_o     <= got_q ? nw_q : (have_front ? ent_q[0].wait_cnt : '0);
      out_front_channel_o   <= have_front ? ent_q[0].channel : '0;
      out_front_net_state_o <= have_front ? ent_q[0].net_state : '0;
      out_front_applet_o    <= have_front ? ent_q[0].applet : '0;
      out_front_dialog_o    <= have_front ? ent_q[0].dialog : '0;
      out_follower_wait_o   <= have_follower ? ent_q[1].wait_cnt : rss_pkg::WAIT_MAX;
    end
  end

endmodule

// File: rtl/rss_checker.sv
// ----------------------------------------------------------------------------
// rss_checker
// Port-level checks of the session stack, bound to the top level.
// ----------------------------------------------------------------------------
module rss_checker #(
  parameter int DEPTH = rss_pkg::DEPTH_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       out_accepted_o,
  input logic [3:0]                 out_slot_o,
  input logic [4:0]                 out_count_o,
  input logic signed [4:0]          out_free_slots_o,
  input logic [rss_pkg::WAIT_W-1:0] out_next_wait_o,
  input logic [rss_pkg::ID_W-1:0]   out_front_channel_o,
  input logic [rss_pkg::ID_W-1:0]   out_front_applet_o,
  input logic [rss_pkg::WAIT_W-1:0] out_follower_wait_o
);

  // a held result word stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // one word at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while busy");

  // count in range and free slots consistent with it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_count_o <= 5'(DEPTH)) &&
                    (out_free_slots_o == 5'(DEPTH) - out_count_o - 5'd1))
    else $error("count and free slots disagree");

  // empty list reports zero front and no follower
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_count_o == '0 |->
      out_next_wait_o == '0 && out_front_channel_o == '0 &&
      out_front_applet_o == '0 && out_follower_wait_o == rss_pkg::WAIT_MAX)
    else $error("empty list reports a session");

  // refused or non-store operations report slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_accepted_o |-> out_slot_o == '0)
    else $error("slot set without a stored session");

endmodule

bind radio_session_stack_top rss_checker #(
  .DEPTH (DEPTH)
) u_rss_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .out_accepted_o      (out_accepted_o),
  .out_slot_o          (out_slot_o),
  .out_count_o         (out_count_o),
  .out_free_slots_o    (out_free_slots_o),
  .out_next_wait_o     (out_next_wait_o),
  .out_front_channel_o (out_front_channel_o),
  .out_front_applet_o  (out_front_applet_o),
  .out_follower_wait_o (out_follower_wait_o)
);

// File: tb/radio_session_stack_top_tb.sv
// ----------------------------------------------------------------------------
// radio_session_stack_top_tb
// Self-checking bench for the radio session list. Directed words walk the
// corner cases, then random words run under several init mask settings. An
// in-bench model of the list predicts each result word, which is compared
// field by field with what the block returns.
// ----------------------------------------------------------------------------

typedef struct packed {
  rss_pkg::op_e op;
  logic [7:0]   applet;
  logic [15:0]  wait_dly;
  logic [7:0]   channel;
  logic [7:0]   net_state;
  logic [7:0]   random_id;
} cmd_word_t;

typedef struct packed {
  logic        accepted;
  logic [3:0]  slot;
  logic [4:0]  count;
  logic [4:0]  free_slots;
  logic [15:0] next_wait;
  logic [7:0]  front_channel;
  logic [7:0]  front_net_state;
  logic [7:0]  front_applet;
  logic [7:0]  front_dialog;
  logic [15:0] follower_wait;
} status_word_t;

class session_list_scoreboard;
  localparam int SLOTS = rss_pkg::DEPTH_DEF;

  rss_pkg::sess_t entries [SLOTS];
  int             held;
  logic [7:0]     init_mask;
  status_word_t   pending_results [$];
  int             mismatches;
  int             checked;
  int             full_seen;

  function new();
    held       = 0;
    init_mask  = rss_pkg::MASK_RESET;
    mismatches = 0;
    checked    = 0;
    full_seen  = 0;
  endfunction

  function bit is_init(int k);
    return (entries[k].net_state & init_mask) != 8'd0;
  endfunction

  function void drop_front();
    if (held > 0) begin
      for (int k = 1; k < held; k++) entries[k-1] = entries[k];
      held--;
    end
  endfunction

  function void insert_at(int pos, rss_pkg::sess_t s);
    for (int k = held; k > pos; k--) entries[k] = entries[k-1];
    entries[pos] = s;
    held++;
  endfunction

  function string fmt(status_word_t r);
    return $sformatf({"acc=%0b slot=%0d cnt=%0d free=%0d next=%h ",
                      "ch=%h ns=%h app=%h dlg=%h fol=%h"},
                     r.accepted, r.slot, r.count, $signed(r.free_slots),
                     r.next_wait, r.front_channel, r.front_net_state,
                     r.front_applet, r.front_dialog, r.follower_wait);
  endfunction

  // apply one accepted word to the list and queue the word it must produce
  function void note_word(cmd_word_t w);
    rss_pkg::sess_t s;
    status_word_t   r;
    int             pos;
    int             k;
    bit             got_next;
    bit             found;
    logic [16:0]    sum;
    s.applet    = w.applet;
    s.wait_cnt  = w.wait_dly;
    s.channel   = w.channel;
    s.net_state = w.net_state;
    s.dialog    = w.random_id;
    r           = '0;
    got_next    = 1'b0;
    found       = 1'b0;
    case (w.op)
      rss_pkg::OP_NEW: begin
        if (held + 2 <= SLOTS) begin
          r.slot     = 4'(held);
          insert_at(held, s);
          r.accepted = 1'b1;
        end
      end
      rss_pkg::OP_EXTEND: begin
        if (held < SLOTS) begin
          pos = held;
          for (k = 1; k < held; k++) begin
            if (!found && is_init(k)) begin
              pos   = k;
              found = 1'b1;
            end
          end
          insert_at(pos, s);
          r.slot     = 4'(pos);
          r.accepted = 1'b1;
        end
      end
      rss_pkg::OP_POP: drop_front();
      rss_pkg::OP_FLUSH: begin
        while (held > 0 && !is_init(0)) drop_front();
      end
      rss_pkg::OP_GETNEXT: begin
        got_next = 1'b1;
        if (held > 0) begin
          r.next_wait         = entries[0].wait_cnt;
          entries[0].wait_cnt = '0;
        end
      end
      rss_pkg::OP_INVITE: begin
        if (held >= 2) begin
          entries[1].wait_cnt  = '0;
          entries[1].net_state = entries[1].net_state & ~init_mask;
        end
      end
      rss_pkg::OP_POSTPONE: begin
        for (k = 0; k < held; k++) begin
          if (!found && is_init(k)) begin
            found = 1'b1;
            sum   = {1'b0, entries[k].wait_cnt} + {1'b0, w.wait_dly};
            entries[k].wait_cnt = sum[16] ? rss_pkg::WAIT_MAX : sum[15:0];
          end
        end
      end
      default: ;
    endcase
    if (!got_next && held > 0) r.next_wait = entries[0].wait_cnt;
    r.count      = 5'(held);
    r.free_slots = 5'(SLOTS - held - 1);
    if (held > 0) begin
      r.front_channel   = entries[0].channel;
      r.front_net_state = entries[0].net_state;
      r.front_applet    = entries[0].applet;
      r.front_dialog    = entries[0].dialog;
    end
    r.follower_wait = (held >= 2) ? entries[1].wait_cnt : rss_pkg::WAIT_MAX;
    if (held == SLOTS) full_seen++;
    pending_results.push_back(r);
  endfunction

  function void check_word(status_word_t got);
    status_word_t exp;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result word with nothing expected: %s", fmt(got));
    end else begin
      exp = pending_results.pop_front();
      checked++;
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on result %0d", checked);
          $display("  expected %s", fmt(exp));
          $display("  actual   %s", fmt(got));
        end
      end
    end
  endfunction
endclass

module radio_session_stack_top_tb;

  localparam int DEPTH        = rss_pkg::DEPTH_DEF;
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_WORDS  = 120;
  localparam int PHASES       = 7;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [rss_pkg::ID_W-1:0]   cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [rss_pkg::OP_W-1:0]   in_op_i;
  logic [rss_pkg::ID_W-1:0]   in_applet_id_i;
  logic [rss_pkg::WAIT_W-1:0] in_wait_or_delay_i;
  logic [rss_pkg::ID_W-1:0]   in_channel_i;
  logic [rss_pkg::ID_W-1:0]   in_net_state_i;
  logic [rss_pkg::ID_W-1:0]   in_random_id_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic                       out_accepted_o;
  logic [3:0]                 out_slot_o;
  logic [4:0]                 out_count_o;
  logic signed [4:0]          out_free_slots_o;
  logic [rss_pkg::WAIT_W-1:0] out_next_wait_o;
  logic [rss_pkg::ID_W-1:0]   out_front_channel_o;
  logic [rss_pkg::ID_W-1:0]   out_front_net_state_o;
  logic [rss_pkg::ID_W-1:0]   out_front_applet_o;
  logic [rss_pkg::ID_W-1:0]   out_front_dialog_o;
  logic [rss_pkg::WAIT_W-1:0] out_follower_wait_o;

  session_list_scoreboard expected_list;
  bit idle_on;
  int hold_requests;
  int words_sent;
  int stalled_cycles;
  int mask_writes;
  int op_seen [8];

  radio_session_stack_top #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .in_op_i               (in_op_i),
    .in_applet_id_i        (in_applet_id_i),
    .in_wait_or_delay_i    (in_wait_or_delay_i),
    .in_channel_i          (in_channel_i),
    .in_net_state_i        (in_net_state_i),
    .in_random_id_i        (in_random_id_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_accepted_o        (out_accepted_o),
    .out_slot_o            (out_slot_o),
    .out_count_o           (out_count_o),
    .out_free_slots_o      (out_free_slots_o),
    .out_next_wait_o       (out_next_wait_o),
    .out_front_channel_o   (out_front_channel_o),
    .out_front_net_state_o (out_front_net_state_o),
    .out_front_applet_o    (out_front_applet_o),
    .out_front_dialog_o    (out_front_dialog_o),
    .out_follower_wait_o   (out_follower_wait_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : cycle_guard
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             expected_list.pending_results.size());
    $display("status: fail");
    $finish;
  end

  function automatic cmd_word_t make_word(rss_pkg::op_e op, logic [7:0] applet,
                                          logic [15:0] wait_dly, logic [7:0] channel,
                                          logic [7:0] net_state, logic [7:0] random_id);
    cmd_word_t w;
    w.op        = op;
    w.applet    = applet;
    w.wait_dly  = wait_dly;
    w.channel   = channel;
    w.net_state = net_state;
    w.random_id = random_id;
    return w;
  endfunction

  function automatic cmd_word_t random_word(logic [7:0] mask);
    cmd_word_t w;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 22)      w.op = rss_pkg::OP_NEW;
    else if (pick < 42) w.op = rss_pkg::OP_EXTEND;
    else if (pick < 54) w.op = rss_pkg::OP_POP;
    else if (pick < 62) w.op = rss_pkg::OP_FLUSH;
    else if (pick < 72) w.op = rss_pkg::OP_GETNEXT;
    else if (pick < 82) w.op = rss_pkg::OP_INVITE;
    else if (pick < 94) w.op = rss_pkg::OP_POSTPONE;
    else                w.op = rss_pkg::OP_QUERY;
    w.applet    = 8'($urandom_range(0, 255));
    w.channel   = 8'($urandom_range(0, 255));
    w.random_id = 8'($urandom_range(0, 255));
    // bias waits toward zero and the top so postpone saturates often
    case ($urandom_range(0, 3))
      0:       w.wait_dly = 16'd0;
      1:       w.wait_dly = 16'(16'hFFFF - $urandom_range(0, 15));
      default: w.wait_dly = 16'($urandom_range(0, 65535));
    endcase
    w.net_state = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 1) w.net_state = w.net_state & ~mask;
    return w;
  endfunction

  task automatic send_word(cmd_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_op_i            <= w.op;
    in_applet_id_i     <= w.applet;
    in_wait_or_delay_i <= w.wait_dly;
    in_channel_i       <= w.channel;
    in_net_state_i     <= w.net_state;
    in_random_id_i     <= w.random_id;
    do begin
      @(posedge clk_i);
      if (in_stall_o) stalled_cycles++;
    end while (in_stall_o);
    expected_list.note_word(w);
    words_sent++;
    op_seen[int'(w.op)]++;
  endtask

  // always waits on the clock after draining so valid is never lowered and raised in one step
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_list.pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_mask(logic [7:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    expected_list.init_mask = value;
    mask_writes++;
  endtask

  initial begin : result_sink
    status_word_t got;
    int           burst;
    int           hold;
    int           holds_served;
    burst        = 0;
    hold         = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.accepted        = out_accepted_o;
        got.slot            = out_slot_o;
        got.count           = out_count_o;
        got.free_slots      = out_free_slots_o;
        got.next_wait       = out_next_wait_o;
        got.front_channel   = out_front_channel_o;
        got.front_net_state = out_front_net_state_o;
        got.front_applet    = out_front_applet_o;
        got.front_dialog    = out_front_dialog_o;
        got.follower_wait   = out_follower_wait_o;
        expected_list.check_word(got);
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold         = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    cmd_word_t  directed [$];
    logic [7:0] masks [PHASES];
    logic [7:0] next_mask;
    int         phase;
    int         n;
    expected_list      = new();
    idle_on            = 1'b1;
    hold_requests      = 0;
    words_sent         = 0;
    stalled_cycles     = 0;
    mask_writes        = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    in_valid_i         <= 1'b0;
    in_op_i            <= '0;
    in_applet_id_i     <= '0;
    in_wait_or_delay_i <= '0;
    in_channel_i       <= '0;
    in_net_state_i     <= '0;
    in_random_id_i     <= '0;
    out_stall_i        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list first, then fill past the new limit, overfill and drain
    directed.push_back(make_word(rss_pkg::OP_QUERY,    8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_POP,      8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_GETNEXT,  8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_FLUSH,    8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_POSTPONE, 8'h00, 16'hFFFF, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_INVITE,   8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_NEW,      8'hFF, 16'hFFFF, 8'h00, 8'h00, 8'hFF));
    directed.push_back(make_word(rss_pkg::OP_INVITE,   8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_NEW,      8'h00, 16'h0000, 8'hFF, 8'hFF, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_NEW,      8'h5A, 16'hFFF0, 8'hA5, 8'h40, 8'h3C));
    directed.push_back(make_word(rss_pkg::OP_NEW,      8'h12, 16'h0007, 8'h34, 8'h56, 8'h78));
    directed.push_back(make_word(rss_pkg::OP_POSTPONE, 8'h00, 16'hFFFF, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_POSTPONE, 8'h00, 16'h0001, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_EXTEND,   8'h11, 16'h1234, 8'h22, 8'h00, 8'h33));
    directed.push_back(make_word(rss_pkg::OP_EXTEND,   8'h99, 16'h4321, 8'h88, 8'h40, 8'h77));
    directed.push_back(make_word(rss_pkg::OP_GETNEXT,  8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_GETNEXT,  8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_INVITE,   8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_FLUSH,    8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_POP,      8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_EXTEND,   8'h77, 16'h0042, 8'hBF, 8'hBF, 8'hC3));
    directed.push_back(make_word(rss_pkg::OP_POSTPONE, 8'h00, 16'h0100, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_QUERY,    8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    directed.push_back(make_word(rss_pkg::OP_FLUSH,    8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_word(rss_pkg::OP_POP,      8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    foreach (directed[i]) send_word(directed[i]);

    // zero entries pick a random mask for that phase
    masks = '{8'hFF, 8'h01, 8'h80, 8'h00, 8'h40, 8'h00, 8'hFF};
    for (phase = 0; phase < PHASES; phase++) begin
      next_mask = masks[phase];
      if (next_mask == 8'h00) next_mask = 8'($urandom_range(1, 255));
      write_mask(next_mask);
      if (phase == PHASES - 1) idle_on = 1'b0;
      for (n = 0; n < PHASE_WORDS; n++) begin
        // long output hold-off so the block backs up into its input
        if (phase == 2 && n == 40) hold_requests++;
        if (phase == 4 && n == 60) wait_drained();
        send_word(random_word(expected_list.init_mask));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words: new %0d, extend %0d, pop %0d, flush %0d, get-next %0d, %s",
             words_sent, op_seen[rss_pkg::OP_NEW], op_seen[rss_pkg::OP_EXTEND],
             op_seen[rss_pkg::OP_POP], op_seen[rss_pkg::OP_FLUSH],
             op_seen[rss_pkg::OP_GETNEXT],
             $sformatf("invite %0d, postpone %0d, query %0d", op_seen[rss_pkg::OP_INVITE],
                       op_seen[rss_pkg::OP_POSTPONE], op_seen[rss_pkg::OP_QUERY]));
    $display({"%0d results checked, %0d mismatches, list full %0d times, ",
              "%0d input stall cycles, %0d mask writes"},
             expected_list.checked, expected_list.mismatches, expected_list.full_seen,
             stalled_cycles, mask_writes);
    if (expected_list.pending_results.size() != 0)
      $display("%0d expected results never arrived", expected_list.pending_results.size());
    if (expected_list.mismatches == 0 && expected_list.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
